// ===== src/nesting_aware_delimiter_splitter_core_macros.svh =====
// Assertion macros shared by the splitter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef NESTING_AWARE_DELIMITER_SPLITTER_CORE_MACROS_SVH
`define NESTING_AWARE_DELIMITER_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NADS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("splitter assertion failed");

// Next-cycle implication, disabled during reset.
`define NADS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("splitter assertion failed");

`endif

// ===== src/nads_pkg.sv =====
// Shared types and constants of the nesting-aware delimiter splitter.
// Depends on nothing; used by the interfaces and all splitter modules.
package nads_pkg;

   localparam int DEPTH_BITS_DEFAULT = 16;
   localparam int BYTE_W             = 8;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 8;
   localparam int DELIM_COUNT_W      = 3;
   localparam int NUM_DELIMS         = 4;

   // Structural characters.
   localparam logic [BYTE_W-1:0] CHAR_LPAREN   = 8'h28;
   localparam logic [BYTE_W-1:0] CHAR_RPAREN   = 8'h29;
   localparam logic [BYTE_W-1:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [BYTE_W-1:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [BYTE_W-1:0] CHAR_RBRACE   = 8'h7D;
   localparam logic [BYTE_W-1:0] CHAR_LANGLE   = 8'h3C;
   localparam logic [BYTE_W-1:0] CHAR_RANGLE   = 8'h3E;
   localparam logic [BYTE_W-1:0] CHAR_DQUOTE   = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_SQUOTE   = 8'h27;
   localparam logic [BYTE_W-1:0] CHAR_COMMA    = 8'h2C;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DELIM_A    = 3'd0,
      REG_DELIM_B    = 3'd1,
      REG_DELIM_C    = 3'd2,
      REG_DELIM_D    = 3'd3,
      REG_DELIM_CNT  = 3'd4,
      REG_ANGLE_EN   = 3'd5,
      REG_DROP_EMPTY = 3'd6
   } csr_index_type;

   // One result word.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_data;
      logic              last_of_item;
   } rsp_word_type;

   // Results caused by one input byte, handed from the step logic to the queue.
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } step_result_type;

   // Configuration seen by the step logic.
   typedef struct packed {
      logic [NUM_DELIMS-1:0][BYTE_W-1:0] delim;
      logic [DELIM_COUNT_W-1:0]          delim_count;
      logic                              angle_enable;
      logic                              drop_empty_delim;
   } cfg_type;

endpackage

// ===== src/nads_req_if.sv =====
// Input channel of the splitter: valid/ready handshake with one text byte per word.
// Depends on nads_pkg.
interface nads_req_if;
   import nads_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== src/nads_rsp_if.sv =====
// Result channel of the splitter: valid/ready handshake with one result per word.
// Depends on nads_pkg.
interface nads_rsp_if;
   import nads_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              is_data;
   logic              last_of_item;

   modport source (output valid, output out_byte, output is_data, output last_of_item,
                   input ready);
   modport sink   (input valid, input out_byte, input is_data, input last_of_item,
                   output ready);
endinterface

// ===== src/nesting_aware_delimiter_splitter_core.sv =====
// Top level of the nesting-aware delimiter splitter: configuration, nesting state, queue.
// Depends on nads_pkg, nads_req_if, nads_rsp_if, nads_step, nads_queue and the macro header.
//
// The splitter takes one text byte per clock while the queue has room, updates its nesting
// depths, quote flags and segment state in the same cycle, and writes zero, one or two
// result words into a four-word output queue. A byte that causes one result keeps the
// block at one byte per cycle while the result port is ready; a byte that also closes the
// segment at end of text adds one extra word, drained by the result port at one word per
// cycle. The input side stays ready while the queue has room for two words, so it takes
// the next byte while earlier words wait; the one-word-per-cycle drain sets throughput.
// Configuration writes are taken at any clock and should be made while the block is idle.
`include "nesting_aware_delimiter_splitter_core_macros.svh"

module nesting_aware_delimiter_splitter_core #(
   parameter int DEPTH_BITS = nads_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   nads_req_if.sink                          req_chan,
   nads_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [nads_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [nads_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import nads_pkg::*;

   cfg_type                      cfg_ff;
   logic signed [DEPTH_BITS-1:0] paren_ff;
   logic signed [DEPTH_BITS-1:0] bracket_ff;
   logic signed [DEPTH_BITS-1:0] brace_ff;
   logic signed [DEPTH_BITS-1:0] angle_ff;
   logic                         dquote_ff;
   logic                         squote_ff;
   logic                         seg_ff;
   logic signed [DEPTH_BITS-1:0] paren_in;
   logic signed [DEPTH_BITS-1:0] bracket_in;
   logic signed [DEPTH_BITS-1:0] brace_in;
   logic signed [DEPTH_BITS-1:0] angle_in;
   logic                         dquote_in;
   logic                         squote_in;
   logic                         seg_in;
   step_result_type              step_res;
   logic                         room;
   logic                         req_fire;

   assign req_chan.ready = room;
   assign req_fire       = req_chan.valid && room;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim            <= {NUM_DELIMS{CHAR_COMMA}};
         cfg_ff.delim_count      <= DELIM_COUNT_W'(1);
         cfg_ff.angle_enable     <= 1'b0;
         cfg_ff.drop_empty_delim <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_DELIM_A:    cfg_ff.delim[0]            <= csr_wdata;
            REG_DELIM_B:    cfg_ff.delim[1]            <= csr_wdata;
            REG_DELIM_C:    cfg_ff.delim[2]            <= csr_wdata;
            REG_DELIM_D:    cfg_ff.delim[3]            <= csr_wdata;
            REG_DELIM_CNT:  cfg_ff.delim_count         <= csr_wdata[DELIM_COUNT_W-1:0];
            REG_ANGLE_EN:   cfg_ff.angle_enable        <= csr_wdata[0];
            REG_DROP_EMPTY: cfg_ff.drop_empty_delim    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Per-byte state update and result generation.
   nads_step #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_step (
      .cfg                   (cfg_ff),
      .text_byte             (req_chan.text_byte),
      .end_of_text           (req_chan.end_of_text),
      .paren_depth           (paren_ff),
      .bracket_depth         (bracket_ff),
      .brace_depth           (brace_ff),
      .angle_depth           (angle_ff),
      .in_double_quote       (dquote_ff),
      .in_single_quote       (squote_ff),
      .segment_nonempty      (seg_ff),
      .paren_depth_next      (paren_in),
      .bracket_depth_next    (bracket_in),
      .brace_depth_next      (brace_in),
      .angle_depth_next      (angle_in),
      .in_double_quote_next  (dquote_in),
      .in_single_quote_next  (squote_in),
      .segment_nonempty_next (seg_in),
      .result                (step_res)
   );

   // Nesting state advances on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         paren_ff   <= '0;
         bracket_ff <= '0;
         brace_ff   <= '0;
         angle_ff   <= '0;
         dquote_ff  <= 1'b0;
         squote_ff  <= 1'b0;
         seg_ff     <= 1'b0;
      end else if (req_fire) begin
         paren_ff   <= paren_in;
         bracket_ff <= bracket_in;
         brace_ff   <= brace_in;
         angle_ff   <= angle_in;
         dquote_ff  <= dquote_in;
         squote_ff  <= squote_in;
         seg_ff     <= seg_in;
      end
   end

   // Result queue toward the output channel.
   nads_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_en  (req_fire),
      .push     (step_res),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

   // End of text leaves every counter and flag cleared.
   `NADS_ASSERT_NEXT(a_eot_clears, clock, reset, req_fire && req_chan.end_of_text, paren_ff == '0 && bracket_ff == '0 && brace_ff == '0 && angle_ff == '0 && !dquote_ff && !squote_ff && !seg_ff)
   // A segment end is never emitted first while the segment is empty, end of text apart.
   `NADS_ASSERT_NOW(a_no_empty_close, clock, reset, req_fire && !seg_ff && step_res.count != 2'd0, step_res.first.is_data || req_chan.end_of_text)
   // Two results only happen at end of text.
   `NADS_ASSERT_NOW(a_two_only_at_eot, clock, reset, req_fire && step_res.count == 2'd2, req_chan.end_of_text)

endmodule

// ===== src/nads_step.sv =====
// Combinational update of the nesting state for one text byte, and the results it causes.
// Depends on nads_pkg.
module nads_step #(
   parameter int DEPTH_BITS = nads_pkg::DEPTH_BITS_DEFAULT
) (
   input  nads_pkg::cfg_type                cfg,
   input  logic [nads_pkg::BYTE_W-1:0]      text_byte,
   input  logic                             end_of_text,
   input  logic signed [DEPTH_BITS-1:0]     paren_depth,
   input  logic signed [DEPTH_BITS-1:0]     bracket_depth,
   input  logic signed [DEPTH_BITS-1:0]     brace_depth,
   input  logic signed [DEPTH_BITS-1:0]     angle_depth,
   input  logic                             in_double_quote,
   input  logic                             in_single_quote,
   input  logic                             segment_nonempty,
   output logic signed [DEPTH_BITS-1:0]     paren_depth_next,
   output logic signed [DEPTH_BITS-1:0]     bracket_depth_next,
   output logic signed [DEPTH_BITS-1:0]     brace_depth_next,
   output logic signed [DEPTH_BITS-1:0]     angle_depth_next,
   output logic                             in_double_quote_next,
   output logic                             in_single_quote_next,
   output logic                             segment_nonempty_next,
   output nads_pkg::step_result_type        result
);
   import nads_pkg::*;

   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

   logic         unquoted;
   logic         dq_mid;
   logic         sq_mid;
   logic         top_level;
   logic         delim_hit;
   logic         first_valid;
   logic         seg_mid;
   logic         close_valid;
   rsp_word_type first_word;
   rsp_word_type close_word;

   // Saturating signed counter step; open and close never coincide.
   function automatic logic signed [DEPTH_BITS-1:0] bump(
      input logic signed [DEPTH_BITS-1:0] d,
      input logic                         open,
      input logic                         close
   );
      logic signed [DEPTH_BITS-1:0] r;
      r = d;
      if (open && d != DEPTH_MAX) begin
         r = d + DEPTH_ONE;
      end else if (close && d != DEPTH_MIN) begin
         r = d - DEPTH_ONE;
      end
      return r;
   endfunction

   // Depths move only outside quotes, using the quote flags from before this byte.
   assign unquoted = !in_double_quote && !in_single_quote;

   logic signed [DEPTH_BITS-1:0] paren_mid;
   logic signed [DEPTH_BITS-1:0] bracket_mid;
   logic signed [DEPTH_BITS-1:0] brace_mid;
   logic signed [DEPTH_BITS-1:0] angle_mid;

   assign paren_mid   = bump(paren_depth, unquoted && text_byte == CHAR_LPAREN,
                             unquoted && text_byte == CHAR_RPAREN);
   assign bracket_mid = bump(bracket_depth, unquoted && text_byte == CHAR_LBRACKET,
                             unquoted && text_byte == CHAR_RBRACKET);
   assign brace_mid   = bump(brace_depth, unquoted && text_byte == CHAR_LBRACE,
                             unquoted && text_byte == CHAR_RBRACE);
   assign angle_mid   = bump(angle_depth,
                             unquoted && cfg.angle_enable && text_byte == CHAR_LANGLE,
                             unquoted && cfg.angle_enable && text_byte == CHAR_RANGLE);

   // Double quote flips first; the single quote then sees the new double-quote flag.
   assign dq_mid = in_double_quote ^ (!in_single_quote && text_byte == CHAR_DQUOTE);
   assign sq_mid = in_single_quote ^ (!dq_mid && text_byte == CHAR_SQUOTE);

   assign top_level = paren_mid == '0 && bracket_mid == '0 && brace_mid == '0 &&
                      (!cfg.angle_enable || angle_mid == '0) && !dq_mid && !sq_mid;

   // Delimiter match over the registers in use; counts above four use all four.
   assign delim_hit = (cfg.delim_count >= 3'd1 && text_byte == cfg.delim[0]) ||
                      (cfg.delim_count >= 3'd2 && text_byte == cfg.delim[1]) ||
                      (cfg.delim_count >= 3'd3 && text_byte == cfg.delim[2]) ||
                      (cfg.delim_count >= 3'd4 && text_byte == cfg.delim[3]);

   // Result of the byte itself: data, segment end, or nothing.
   always_comb begin
      first_word.out_byte     = text_byte;
      first_word.is_data      = 1'b1;
      first_word.last_of_item = 1'b0;
      first_valid             = 1'b1;
      seg_mid                 = 1'b1;
      if (top_level && delim_hit) begin
         if (segment_nonempty) begin
            first_word.out_byte = '0;
            first_word.is_data  = 1'b0;
            seg_mid             = 1'b0;
         end else if (cfg.drop_empty_delim) begin
            first_valid = 1'b0;
            seg_mid     = 1'b0;
         end
      end
   end

   // End of text closes a nonempty segment.
   assign close_valid             = end_of_text && seg_mid;
   assign close_word.out_byte     = '0;
   assign close_word.is_data      = 1'b0;
   assign close_word.last_of_item = 1'b1;

   // Pack the results in order and mark the final one.
   always_comb begin
      result.count  = {1'b0, first_valid} + {1'b0, close_valid};
      result.first  = first_word;
      result.second = close_word;
      if (!first_valid) begin
         result.first = close_word;
      end else if (!close_valid) begin
         result.first.last_of_item = 1'b1;
      end
   end

   // End of text clears all state.
   assign paren_depth_next      = end_of_text ? '0 : paren_mid;
   assign bracket_depth_next    = end_of_text ? '0 : bracket_mid;
   assign brace_depth_next      = end_of_text ? '0 : brace_mid;
   assign angle_depth_next      = end_of_text ? '0 : angle_mid;
   assign in_double_quote_next  = !end_of_text && dq_mid;
   assign in_single_quote_next  = !end_of_text && sq_mid;
   assign segment_nonempty_next = !end_of_text && seg_mid;

endmodule

// ===== src/nads_queue.sv =====
// Four-word result queue that takes up to two words per cycle and drives the result channel.
// Depends on nads_pkg, nads_rsp_if and the assertion macro header.
`include "nesting_aware_delimiter_splitter_core_macros.svh"

module nads_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_en,
   input  nads_pkg::step_result_type  push,
   output logic                       room,
   nads_rsp_if.source                 rsp_chan
);
   import nads_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;

   rsp_word_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] push_cnt;
   logic             pop;
   rsp_word_type     head;

   assign push_cnt = push_en ? CNT_W'(push.count) : '0;
   assign pop      = rsp_chan.valid && rsp_chan.ready;

   // Room for the two words an input byte may cause.
   assign room = count_ff <= CNT_W'(QUEUE_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + push_cnt[PTR_W-1:0];
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + push_cnt - CNT_W'(pop);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage.
   always_ff @(posedge clock) begin
      if (push_cnt >= CNT_W'(1)) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push_cnt >= CNT_W'(2)) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   // Head of the queue drives the result channel.
   assign head                  = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.out_byte     = head.out_byte;
   assign rsp_chan.is_data      = head.is_data;
   assign rsp_chan.last_of_item = head.last_of_item;

   `NADS_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   // A waiting word stays offered and unchanged until it is taken.
   `NADS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(head))
   // An accepted input byte never overfills the queue.
   `NADS_ASSERT_NOW(a_push_fits, clock, reset, push_en, count_ff + push_cnt <= CNT_W'(QUEUE_DEPTH))

endmodule

// ===== sim/nesting_aware_delimiter_splitter_core_test.sv =====
// Self-checking testbench for nesting_aware_delimiter_splitter_core: random and directed text.
// Depends on nads_pkg, nads_req_if, nads_rsp_if and the splitter RTL; predicts every result word.
module nesting_aware_delimiter_splitter_core_test;
   import nads_pkg::*;

   // Narrow depth counters so that saturation is reached within short strings.
   localparam int DEPTH_W      = 4;
   localparam int LEVEL_MAX    = (1 << (DEPTH_W - 1)) - 1;
   localparam int LEVEL_MIN    = -LEVEL_MAX - 1;
   localparam int SETTLE_CYC   = 8;
   localparam int HOLD_CYC     = 300;
   localparam int PHASE_ITEMS  = 130;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic [BYTE_W-1:0] text;
      logic              eot;
   } text_item_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   nads_req_if req_bus ();
   nads_rsp_if rsp_bus ();

   nesting_aware_delimiter_splitter_core #(
      .DEPTH_BITS (DEPTH_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and expectation stores.
   text_item_type bytes_to_send[$];
   text_item_type draft[$];
   rsp_word_type  expected_words[$];

   // Predicted block state and configuration.
   int                paren_lvl, bracket_lvl, brace_lvl, angle_lvl;
   bit                in_dq, in_sq, seg_open;
   logic [BYTE_W-1:0] cfg_delim [NUM_DELIMS];
   logic [2:0]        cfg_count;
   bit                cfg_angle, cfg_drop;

   // Delimiters that the stimulus side has configured, used to aim random text.
   logic [BYTE_W-1:0] chosen_delims [NUM_DELIMS];

   bit req_fire;
   bit hold_start;
   bit hold_rsp;
   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int items_taken;
   int words_checked;
   int segment_ends;
   int stall_cycles;

   // Clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int level_up(int v);
      return (v < LEVEL_MAX) ? v + 1 : v;
   endfunction

   function automatic int level_down(int v);
      return (v > LEVEL_MIN) ? v - 1 : v;
   endfunction

   // A count above four still means all four delimiter registers.
   function automatic bit is_split_char(logic [BYTE_W-1:0] b);
      int n;
      n = (cfg_count > 3'd4) ? 4 : int'(cfg_count);
      for (int i = 0; i < n; i++) begin
         if (b == cfg_delim[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic clear_nesting();
      paren_lvl   = 0;
      bracket_lvl = 0;
      brace_lvl   = 0;
      angle_lvl   = 0;
      in_dq       = 1'b0;
      in_sq       = 1'b0;
      seg_open    = 1'b0;
   endtask

   // Works out the result words of one accepted byte and queues them.
   task automatic predict_split(input logic [BYTE_W-1:0] b, input logic eot);
      rsp_word_type words[$];
      bit           top;
      // Depths move only outside quotes, using the quote flags from before this byte.
      if (!in_dq && !in_sq) begin
         case (b)
            CHAR_LPAREN:   paren_lvl   = level_up(paren_lvl);
            CHAR_RPAREN:   paren_lvl   = level_down(paren_lvl);
            CHAR_LBRACKET: bracket_lvl = level_up(bracket_lvl);
            CHAR_RBRACKET: bracket_lvl = level_down(bracket_lvl);
            CHAR_LBRACE:   brace_lvl   = level_up(brace_lvl);
            CHAR_RBRACE:   brace_lvl   = level_down(brace_lvl);
            CHAR_LANGLE:   if (cfg_angle) angle_lvl = level_up(angle_lvl);
            CHAR_RANGLE:   if (cfg_angle) angle_lvl = level_down(angle_lvl);
            default: ;
         endcase
      end
      if (!in_sq && b == CHAR_DQUOTE) in_dq = !in_dq;
      if (!in_dq && b == CHAR_SQUOTE) in_sq = !in_sq;

      // A negative depth is not top level either.
      top = paren_lvl == 0 && bracket_lvl == 0 && brace_lvl == 0 &&
            (!cfg_angle || angle_lvl == 0) && !in_dq && !in_sq;

      if (top && is_split_char(b)) begin
         if (seg_open) begin
            words.insert(words.size(), '{out_byte: '0, is_data: 1'b0, last_of_item: 1'b0});
            seg_open = 1'b0;
         end else if (!cfg_drop) begin
            words.insert(words.size(), '{out_byte: b, is_data: 1'b1, last_of_item: 1'b0});
            seg_open = 1'b1;
         end
      end else begin
         words.insert(words.size(), '{out_byte: b, is_data: 1'b1, last_of_item: 1'b0});
         seg_open = 1'b1;
      end

      // The last byte closes a nonempty segment and clears all nesting state.
      if (eot) begin
         if (seg_open) begin
            words.insert(words.size(), '{out_byte: '0, is_data: 1'b0, last_of_item: 1'b0});
         end
         clear_nesting();
      end

      if (words.size() > 0) words[words.size() - 1].last_of_item = 1'b1;
      foreach (words[i]) expected_words.insert(expected_words.size(), words[i]);
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Monitor: tracks configuration writes, predicts accepted bytes, checks result words.
   always @(posedge clock) begin : monitor_proc
      rsp_word_type got_word;
      rsp_word_type want_word;
      if (reset) begin
         req_fire <= 1'b0;
         for (int i = 0; i < NUM_DELIMS; i++) cfg_delim[i] = CHAR_COMMA;
         cfg_count = 3'd1;
         cfg_angle = 1'b0;
         cfg_drop  = 1'b0;
         clear_nesting();
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (csr_we) begin
            case (csr_index)
               REG_DELIM_A:    cfg_delim[0] = csr_wdata;
               REG_DELIM_B:    cfg_delim[1] = csr_wdata;
               REG_DELIM_C:    cfg_delim[2] = csr_wdata;
               REG_DELIM_D:    cfg_delim[3] = csr_wdata;
               REG_DELIM_CNT:  cfg_count    = csr_wdata[2:0];
               REG_ANGLE_EN:   cfg_angle    = csr_wdata[0];
               REG_DROP_EMPTY: cfg_drop     = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_bus.valid && !req_bus.ready) stall_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            items_taken++;
            predict_split(req_bus.text_byte, req_bus.end_of_text);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_word = '{out_byte: rsp_bus.out_byte, is_data: rsp_bus.is_data,
                         last_of_item: rsp_bus.last_of_item};
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, got byte %0h data %0b last %0b",
                        $time, got_word.out_byte, got_word.is_data, got_word.last_of_item);
            end else begin
               want_word = expected_words.pop_front();
               words_checked++;
               if (!want_word.is_data) segment_ends++;
               check_field("out_byte", want_word.out_byte, got_word.out_byte);
               check_field("is_data", want_word.is_data, got_word.is_data);
               check_field("last_of_item", want_word.last_of_item, got_word.last_of_item);
            end
         end
      end
   end

   // Driver: offers queued bytes, holding each one until it is taken.
   always @(negedge clock) begin : driver_proc
      text_item_type item;
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.text_byte   <= '0;
         req_bus.end_of_text <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            item = bytes_to_send.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.text_byte   <= item.text;
            req_bus.end_of_text <= item.eot;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off.
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else       rsp_bus.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      hold_rsp = 1'b0;
      wait (hold_start);
      hold_rsp = 1'b1;
      repeat (HOLD_CYC) @(posedge clock);
      hold_rsp = 1'b0;
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      draft.insert(draft.size(), '{text: b, eot: 1'b0});
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   // Hands the drafted string to the driver in one go; returns how many bytes it held.
   task automatic commit_draft(input bit eot, output int n);
      n = draft.size();
      if (n > 0) draft[n - 1].eot = eot;
      foreach (draft[i]) bytes_to_send.insert(bytes_to_send.size(), draft[i]);
      draft.delete();
   endtask

   // Ordinary text: mostly letters and delimiters, some arbitrary bytes.
   function automatic logic [BYTE_W-1:0] pick_filler();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)      return 8'h61 + BYTE_W'($urandom_range(25));
      else if (pick < 65) return chosen_delims[$urandom_range(NUM_DELIMS - 1)];
      else if (pick < 75) return CHAR_COMMA;
      else                return BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [BYTE_W-1:0] pick_structural();
      case ($urandom_range(9))
         0: return CHAR_LPAREN;
         1: return CHAR_RPAREN;
         2: return CHAR_LBRACKET;
         3: return CHAR_RBRACKET;
         4: return CHAR_LBRACE;
         5: return CHAR_RBRACE;
         6: return CHAR_LANGLE;
         7: return CHAR_RANGLE;
         8: return CHAR_DQUOTE;
         default: return CHAR_SQUOTE;
      endcase
   endfunction

   // Mostly well-formed string: balanced nesting and closed quotes; filler may add stray structure.
   task automatic draft_balanced(input int len);
      logic [BYTE_W-1:0] closers[$];
      logic [BYTE_W-1:0] quote_char;
      int                pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            case ($urandom_range(3))
               0: begin
                  push_byte(CHAR_LPAREN);
                  closers.insert(closers.size(), CHAR_RPAREN);
               end
               1: begin
                  push_byte(CHAR_LBRACKET);
                  closers.insert(closers.size(), CHAR_RBRACKET);
               end
               2: begin
                  push_byte(CHAR_LBRACE);
                  closers.insert(closers.size(), CHAR_RBRACE);
               end
               default: begin
                  push_byte(CHAR_LANGLE);
                  closers.insert(closers.size(), CHAR_RANGLE);
               end
            endcase
         end else if (pick < 30 && closers.size() > 0) begin
            push_byte(closers.pop_back());
         end else if (pick < 38) begin
            // Quoted run; the other quote and brackets inside it are plain text.
            quote_char = $urandom_range(1) ? CHAR_DQUOTE : CHAR_SQUOTE;
            push_byte(quote_char);
            repeat ($urandom_range(3)) begin
               case ($urandom_range(3))
                  0: push_byte(quote_char == CHAR_DQUOTE ? CHAR_SQUOTE : CHAR_DQUOTE);
                  1: push_byte(CHAR_LPAREN);
                  default: push_byte(pick_filler());
               endcase
            end
            push_byte(quote_char);
         end else begin
            push_byte(pick_filler());
         end
      end
      while (closers.size() > 0) push_byte(closers.pop_back());
   endtask

   // Noise: unbalanced structure, stray quotes and long runs that saturate a depth.
   task automatic draft_noise(input int len);
      logic [BYTE_W-1:0] run_char;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(9))
            0: begin
               run_char = pick_structural();
               repeat (LEVEL_MAX + $urandom_range(2, 4)) push_byte(run_char);
            end
            1, 2, 3, 4: push_byte(pick_structural());
            default:    push_byte(pick_filler());
         endcase
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Writes every register; the stimulus side keeps the delimiters for aiming.
   task automatic apply_setup(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input logic [7:0] d,
                              input logic [7:0] count, input logic [7:0] angle,
                              input logic [7:0] drop);
      write_reg(REG_DELIM_A, a);
      write_reg(REG_DELIM_B, b);
      write_reg(REG_DELIM_C, c);
      write_reg(REG_DELIM_D, d);
      write_reg(REG_DELIM_CNT, count);
      write_reg(REG_ANGLE_EN, angle);
      write_reg(REG_DROP_EMPTY, drop);
      chosen_delims[0] = a;
      chosen_delims[1] = b;
      chosen_delims[2] = c;
      chosen_delims[3] = d;
   endtask

   // Waits until every byte is taken and every word has come, then lets the block settle.
   task automatic wait_quiet();
      do @(negedge clock);
      while (bytes_to_send.size() > 0 || (req_bus.valid && !req_fire) ||
             expected_words.size() > 0);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   // Stimulus: directed strings, then random phases under changing settings.
   initial begin : stimulus_proc
      int added;
      int phase_items;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      hold_start          = 1'b0;
      send_idle_pct       = 11;
      recv_idle_pct       = 73;
      fail_count          = 0;
      items_taken         = 0;
      words_checked       = 0;
      segment_ends        = 0;
      stall_cycles        = 0;
      for (int i = 0; i < NUM_DELIMS; i++) chosen_delims[i] = CHAR_COMMA;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               apply_setup(8'h3B, 8'h7C, 8'h00, 8'hFF, 8'd4, 8'd1, 8'd1);
               // An unknown index must leave every register alone.
               write_reg(REG_UNUSED, 8'h2E);
            end
            2: apply_setup(8'h2C, 8'h3A, 8'h20, 8'hFF, 8'd0, 8'd0, 8'd0);
            3: apply_setup(8'hFF, 8'h2C, 8'h3C, 8'h00, 8'd7, 8'd1, 8'd0);
            4: apply_setup(8'h2C, 8'h3B, 8'h2C, 8'h2C, 8'd2, 8'd0, 8'd1);
            5: apply_setup(8'h2E, 8'h2C, 8'h3E, 8'h29, 8'hFB, 8'hFF, 8'hFE);
            default: ;
         endcase
         send_idle_pct = (phase < 2) ? 11 : (phase < 4) ? 73 : 0;
         recv_idle_pct = (phase < 2) ? 73 : (phase < 4) ? 11 : 0;

         if (phase == 0) begin
            // Empty-segment delimiter kept as text, then a split.
            push_text(",a,");
            // Delimiter inside parentheses, then at a negative depth.
            push_text("(,)),");
            push_byte(8'hFF);
            commit_draft(1'b1, added);
            // Quotes shield each other, brackets and delimiters.
            push_text("\",'\",'\"(',");
            push_byte(8'h00);
            commit_draft(1'b1, added);
            // Angle brackets are plain text while angle nesting is off.
            push_text("[]{}<,");
            commit_draft(1'b1, added);
         end

         // Long receiver hold-off while the sender keeps offering bytes.
         if (phase == 4) hold_start = 1'b1;

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(99) < 75) draft_balanced($urandom_range(1, 16));
            else                         draft_noise($urandom_range(1, 10));
            commit_draft($urandom_range(99) < 92, added);
            phase_items += added;
         end
         wait_quiet();
      end

      $display("Checked %0d result words (%0d segment ends) from %0d text bytes.",
               words_checked, segment_ends, items_taken);
      $display("Six settings, including no delimiters, all four and a long output stall "
               , "(%0d input stall cycles).", stall_cycles);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
